// ----- rtl/imuf_pkg.sv -----
// IMU link deframer: shared types and constants.
// Used by the parser, result queue, top level and checker; no dependencies.
package imuf_pkg;

	localparam logic [7:0] DATA_CONTROL = 8'h40;
	localparam logic [7:0] DATA_ID      = 8'h52;
	localparam logic [7:0] MAX_LENGTH   = 8'd126;
	localparam logic [3:0] NO_FIELD     = 4'd15;

	localparam int TDATA_W = 72;

	typedef struct packed {
		logic        kind;
		logic [3:0]  quantity;
		logic [31:0] value_bits;
		logic [1:0]  frame_type;
		logic [7:0]  control_value;
		logic [7:0]  length_value;
		logic [7:0]  message_id;
		logic [7:0]  nack_code;
		logic        length_error;
		logic        last_of_run;
	} result_t;

endpackage

// ----- rtl/imuf_parser.sv -----
// IMU link deframer: frame parser, one byte per cycle, up to two results per byte.
// Depends on imuf_pkg.
module imuf_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_sof,
	input  logic [5:0]          mask,
	output logic [1:0]          res_count,
	output imuf_pkg::result_t   res0,
	output imuf_pkg::result_t   res1
);

	typedef enum logic [1:0] {PH_IDLE, PH_LEN, PH_ID, PH_PAYLOAD} phase_t;

	function automatic logic [2:0] group_of(input logic [3:0] q);
		logic [2:0] g;
		case (q) inside
			[4'd1:4'd3]: g = 3'd0;
			[4'd4:4'd6]: g = 3'd1;
			[4'd7:4'd9]: g = 3'd2;
			4'd10:       g = 3'd3;
			4'd11:       g = 3'd4;
			default:     g = 3'd5;
		endcase
		return g;
	endfunction

	function automatic logic is_wide(input logic [3:0] q);
		return (q == 4'd10) || (q >= 4'd12 && q <= 4'd14);
	endfunction

	function automatic logic [3:0] next_field(input logic [3:0] q, input logic [5:0] m);
		logic [3:0] r;
		r = imuf_pkg::NO_FIELD;
		for (int n = 14; n >= 1; n--) begin
			if (4'(n) > q && m[group_of(4'(n))]) r = 4'(n);
		end
		return r;
	endfunction

	function automatic imuf_pkg::result_t make_summary(input logic [7:0] ctrl,
			input logic [7:0] len, input logic [7:0] id, input logic [7:0] nack,
			input logic err);
		imuf_pkg::result_t r;
		r = '0;
		r.kind          = 1'b1;
		r.frame_type    = ctrl[7:6];
		r.control_value = ctrl;
		r.length_value  = len;
		r.message_id    = err ? 8'd0 : id;
		r.nack_code     = err ? 8'd0 : nack;
		r.length_error  = err;
		return r;
	endfunction

	phase_t      phase_q, phase_d;
	logic [7:0]  control_q, control_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  nack_q, nack_d;
	logic [6:0]  pcount_q, pcount_d;
	logic [31:0] shift_q, shift_d;
	logic [3:0]  findex_q, findex_d;
	logic [1:0]  fbytes_q, fbytes_d;
	logic        is_data_q, is_data_d;

	logic [31:0] shift_n;
	logic [2:0]  fbytes_n;
	logic [31:0] val;
	logic [7:0]  pcount_p1;

	always_comb begin
		phase_d   = phase_q;
		control_d = control_q;
		length_d  = length_q;
		id_d      = id_q;
		nack_d    = nack_q;
		pcount_d  = pcount_q;
		shift_d   = shift_q;
		findex_d  = findex_q;
		fbytes_d  = fbytes_q;
		is_data_d = is_data_q;
		res_count = 2'd0;
		res0      = '0;
		res1      = '0;
		shift_n   = {shift_q[23:0], in_byte};
		fbytes_n  = {1'b0, fbytes_q} + 3'd1;
		val       = shift_n;
		pcount_p1 = {1'b0, pcount_q} + 8'd1;
		if (!is_wide(findex_q)) begin
			val = {{16{shift_n[15] && findex_q != 4'd0}}, shift_n[15:0]};
		end
		if (in_valid) begin
			if (in_sof) begin
				control_d = in_byte;
				length_d  = '0;
				id_d      = '0;
				nack_d    = '0;
				pcount_d  = '0;
				shift_d   = '0;
				findex_d  = '0;
				fbytes_d  = '0;
				is_data_d = 1'b0;
				phase_d   = PH_LEN;
			end else begin
				case (phase_q)
					PH_IDLE: begin
					end
					PH_LEN: begin
						length_d = in_byte;
						if (in_byte > imuf_pkg::MAX_LENGTH) begin
							res0      = make_summary(control_q, in_byte, id_q, nack_q, 1'b1);
							res_count = 2'd1;
							phase_d   = PH_IDLE;
						end else begin
							phase_d = PH_ID;
						end
					end
					PH_ID: begin
						id_d      = in_byte;
						is_data_d = control_q == imuf_pkg::DATA_CONTROL &&
							in_byte == imuf_pkg::DATA_ID && length_q > 8'd3;
						findex_d  = '0;
						fbytes_d  = '0;
						shift_d   = '0;
						pcount_d  = '0;
						if (length_q <= 8'd1) begin
							res0      = make_summary(control_q, length_q, in_byte, nack_q, 1'b0);
							res_count = 2'd1;
							phase_d   = PH_IDLE;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (pcount_q == 7'd0) nack_d = in_byte;
						if (is_data_q && findex_q != imuf_pkg::NO_FIELD) begin
							if (fbytes_n >= (is_wide(findex_q) ? 3'd4 : 3'd2)) begin
								res0            = '0;
								res0.quantity   = findex_q;
								res0.value_bits = val;
								res_count       = 2'd1;
								findex_d        = next_field(findex_q, mask);
								shift_d         = '0;
								fbytes_d        = '0;
							end else begin
								shift_d  = shift_n;
								fbytes_d = fbytes_n[1:0];
							end
						end
						pcount_d = pcount_p1[6:0];
						if (pcount_p1 + 8'd1 >= length_q) begin
							if (res_count == 2'd1) begin
								res1      = make_summary(control_q, length_q, id_q, nack_d, 1'b0);
								res_count = 2'd2;
							end else begin
								res0      = make_summary(control_q, length_q, id_q, nack_d, 1'b0);
								res_count = 2'd1;
							end
							phase_d = PH_IDLE;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
		if (res_count == 2'd1) res0.last_of_run = 1'b1;
		if (res_count == 2'd2) res1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			control_q <= '0;
			length_q  <= '0;
			id_q      <= '0;
			nack_q    <= '0;
			pcount_q  <= '0;
			shift_q   <= '0;
			findex_q  <= '0;
			fbytes_q  <= '0;
			is_data_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			control_q <= control_d;
			length_q  <= length_d;
			id_q      <= id_d;
			nack_q    <= nack_d;
			pcount_q  <= pcount_d;
			shift_q   <= shift_d;
			findex_q  <= findex_d;
			fbytes_q  <= fbytes_d;
			is_data_q <= is_data_d;
		end
	end

endmodule

// ----- rtl/imuf_result_queue.sv -----
// IMU link deframer: result queue, two pushes and one pop per cycle.
// Depends on imuf_pkg.
module imuf_result_queue #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_count,
	input  imuf_pkg::result_t             push0,
	input  imuf_pkg::result_t             push1,
	input  logic                          pop,
	output logic                          out_valid,
	output imuf_pkg::result_t             out_data,
	output logic [$clog2(DEPTH+1)-1:0]    count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [IW-1:0] inc(input logic [IW-1:0] p);
		return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
	endfunction

	imuf_pkg::result_t mem_q [DEPTH];
	logic [IW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign do_pop    = pop && count_q != '0;
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) mem_q[wr_q] <= push0;
		if (push_count == 2'd2) mem_q[inc(wr_q)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_count == 2'd1) wr_q <= inc(wr_q);
			else if (push_count == 2'd2) wr_q <= inc(inc(wr_q));
			if (do_pop) rd_q <= inc(rd_q);
			count_q <= count_q + CW'(push_count) - CW'(do_pop);
		end
	end

endmodule

// ----- rtl/imu_frame_deframer_top.sv -----
// IMU link deframer top level: input register, parser and result queue.
// Depends on imuf_pkg, imuf_parser and imuf_result_queue.

// Takes one received byte per cycle and is ready again at once while the
// result queue has room; results leave at one beat per cycle while m_tready is
// high, so a byte that completes a field and ends the frame costs two output
// beats. The first result of a byte reaches the output through the input
// register, then the queue, and can leave at the next edge.
// DEPTH (at least 4) sizes the result queue; ready drops when the queue and
// the byte in flight could not absorb two more results.
module imu_frame_deframer_top #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [5:0]                    cfg_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // rx_byte
	input  logic                          s_tuser,  // start_of_frame
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// quantity, value_bits, frame_type, control_value, length_value, message_id,
	// nack_code, length_error, zero pad
	output logic [imuf_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tuser,  // result_kind
	output logic                          m_tlast   // last_of_run
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [5:0]        mask_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              sof_s1;
	logic [1:0]        res_count;
	imuf_pkg::result_t res0, res1, head;
	logic [CW-1:0]     count;
	logic [CW:0]       occupancy;

	assign occupancy = {1'b0, count} + {{(CW-1){1'b0}}, valid_s1, 1'b0};
	assign s_tready  = occupancy <= (CW+1)'(DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= 6'd63;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) mask_q <= cfg_wr_data;
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
	end

	imuf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_byte   (byte_s1),
		.in_sof    (sof_s1),
		.mask      (mask_q),
		.res_count (res_count),
		.res0      (res0),
		.res1      (res1)
	);

	imuf_result_queue #(.DEPTH(DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (res_count),
		.push0      (res0),
		.push1      (res1),
		.pop        (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (head),
		.count      (count)
	);

	assign m_tuser = head.kind;
	assign m_tlast = head.last_of_run;
	assign m_tdata = {1'b0, head.length_error, head.nack_code, head.message_id,
		head.length_value, head.control_value, head.frame_type, head.value_bits,
		head.quantity};

endmodule

// ----- rtl/imuf_checker.sv -----
// IMU link deframer: port-level checker and its bind to the top level.
// Depends on imuf_pkg and imu_frame_deframer_top.
module imuf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [imuf_pkg::TDATA_W-1:0]  m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output beat during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata[35:0] == 36'd0)
		else $error("summary beat not last or carries a value");

	a_value_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[71:36] == 36'd0)
		else $error("value beat carries header fields");

	a_len_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[70] |-> m_tuser && m_tdata[69:54] == 16'd0)
		else $error("length error beat carries id or nack code");

endmodule

bind imu_frame_deframer_top imuf_checker u_imuf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for imu_frame_deframer_top: frame bytes in, decoded values and
// frame summaries out, compared against a cycle-free predictor held in a small scoreboard.
// Depends on imuf_pkg and the deframer RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_ITEMS = 1900;
	localparam int PHASE_ITEMS  = 240;
	localparam int LONG_STALL   = 300;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [3:0] Q_COUNTER  = 4'd0;
	localparam logic [3:0] Q_ACC_X    = 4'd1;
	localparam logic [3:0] Q_GYR_X    = 4'd4;
	localparam logic [3:0] Q_MAG_X    = 4'd7;
	localparam logic [3:0] Q_PRESSURE = 4'd10;
	localparam logic [3:0] Q_TEMP     = 4'd11;
	localparam logic [3:0] Q_YAW      = 4'd14;

	localparam logic [7:0] CTRL_CONTROL = 8'h00;
	localparam logic [7:0] CTRL_ACK     = 8'h80;
	localparam logic [7:0] CTRL_NACK    = 8'hC0;

	typedef enum logic [1:0] {
		WAIT_CTRL,
		WAIT_LEN,
		WAIT_ID,
		IN_PAYLOAD
	} parse_state_t;

	class frame_scoreboard;
		imuf_pkg::result_t expected_results[$];
		int           errors;
		int           counted;
		int           frames_started;
		int           values_seen;
		int           summaries_seen;
		logic [5:0]   mask;
		parse_state_t state;
		logic [7:0]   ctrl_r, len_r, id_r, nack_r;
		logic [7:0]   pay_cnt;
		logic [31:0]  shift_r;
		logic [3:0]   fidx;
		int           fbytes;
		logic         is_data;

		function new();
			mask = 6'd63;
			state = WAIT_CTRL;
			ctrl_r = '0;
			len_r = '0;
			id_r = '0;
			nack_r = '0;
			pay_cnt = '0;
			shift_r = '0;
			fidx = Q_COUNTER;
			fbytes = 0;
			is_data = 1'b0;
		endfunction

		function void set_mask(logic [5:0] m);
			mask = m;
		endfunction

		function int group_of(logic [3:0] q);
			if (q >= Q_ACC_X && q < Q_GYR_X) return 0;
			if (q >= Q_GYR_X && q < Q_MAG_X) return 1;
			if (q >= Q_MAG_X && q < Q_PRESSURE) return 2;
			if (q == Q_PRESSURE) return 3;
			if (q == Q_TEMP) return 4;
			return 5;
		endfunction

		function int width_of(logic [3:0] q);
			return (q == Q_PRESSURE || q > Q_TEMP) ? 4 : 2;
		endfunction

		function logic [3:0] next_field(logic [3:0] q);
			for (int n = q + 1; n <= Q_YAW; n++)
				if (mask[group_of(4'(n))]) return 4'(n);
			return imuf_pkg::NO_FIELD;
		endfunction

		function imuf_pkg::result_t summary(logic err);
			imuf_pkg::result_t r;
			r = '0;
			r.kind = 1'b1;
			r.frame_type = ctrl_r[7:6];
			r.control_value = ctrl_r;
			r.length_value = len_r;
			r.message_id = err ? 8'd0 : id_r;
			r.nack_code = err ? 8'd0 : nack_r;
			r.length_error = err;
			return r;
		endfunction

		// Advance the parser by one accepted beat and queue the results it causes.
		function void note_byte(logic [7:0] rx, logic sof);
			imuf_pkg::result_t out[$];
			imuf_pkg::result_t r;
			logic [31:0] v;
			if (sof) begin
				ctrl_r = rx;
				len_r = '0;
				id_r = '0;
				nack_r = '0;
				pay_cnt = '0;
				shift_r = '0;
				fidx = Q_COUNTER;
				fbytes = 0;
				is_data = 1'b0;
				state = WAIT_LEN;
				counted++;
				frames_started++;
				return;
			end
			case (state)
				WAIT_LEN: begin
					len_r = rx;
					if (rx > imuf_pkg::MAX_LENGTH) begin
						out.push_back(summary(1'b1));
						state = WAIT_CTRL;
					end else begin
						state = WAIT_ID;
					end
				end
				WAIT_ID: begin
					id_r = rx;
					is_data = ctrl_r == imuf_pkg::DATA_CONTROL && id_r == imuf_pkg::DATA_ID &&
						len_r > 8'd3;
					fidx = Q_COUNTER;
					fbytes = 0;
					shift_r = '0;
					pay_cnt = '0;
					if (len_r <= 8'd1) begin
						out.push_back(summary(1'b0));
						state = WAIT_CTRL;
					end else begin
						state = IN_PAYLOAD;
					end
				end
				IN_PAYLOAD: begin
					if (pay_cnt == 8'd0) nack_r = rx;
					if (is_data && fidx != imuf_pkg::NO_FIELD) begin
						shift_r = {shift_r[23:0], rx};
						fbytes++;
						if (fbytes >= width_of(fidx)) begin
							v = shift_r;
							if (width_of(fidx) == 2) begin
								v = {16'h0000, shift_r[15:0]};
								if (fidx != Q_COUNTER && v[15]) v[31:16] = 16'hFFFF;
							end
							r = '0;
							r.quantity = fidx;
							r.value_bits = v;
							out.push_back(r);
							fidx = next_field(fidx);
							shift_r = '0;
							fbytes = 0;
						end
					end
					pay_cnt++;
					if (int'(pay_cnt) + 1 >= int'(len_r)) begin
						out.push_back(summary(1'b0));
						state = WAIT_CTRL;
					end
				end
				default: return;
			endcase
			counted++;
			if (out.size() > 0) out[out.size()-1].last_of_run = 1'b1;
			foreach (out[i]) expected_results.push_back(out[i]);
		endfunction

		function void check_beat(imuf_pkg::result_t got);
			imuf_pkg::result_t want;
			logic [31:0] gf[10], wf[10];
			string names[10];
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat kind=%0d quantity=%0d value=%h",
					$time, got.kind, got.quantity, got.value_bits);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			names = '{"result_kind", "quantity", "value_bits", "frame_type", "control_value",
				"length_value", "message_id", "nack_code", "length_error", "last_of_run"};
			gf = '{got.kind, got.quantity, got.value_bits, got.frame_type, got.control_value,
				got.length_value, got.message_id, got.nack_code, got.length_error,
				got.last_of_run};
			wf = '{want.kind, want.quantity, want.value_bits, want.frame_type,
				want.control_value, want.length_value, want.message_id, want.nack_code,
				want.length_error, want.last_of_run};
			foreach (gf[i])
				if (gf[i] !== wf[i]) begin
					$display("%0t: %s mismatch: expected %h, actual %h",
						$time, names[i], wf[i], gf[i]);
					errors++;
				end
			if (want.kind) summaries_seen++;
			else values_seen++;
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [5:0]                     cfg_wr_data;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [imuf_pkg::TDATA_W-1:0]   m_tdata;
	logic                           m_tuser;
	logic                           m_tlast;

	frame_scoreboard sb = new();

	logic [7:0] frame_q[$];
	int         burst_left;
	bit         gaps_on;
	bit         stall_request;
	int         mask_writes;

	imu_frame_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		imuf_pkg::result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			r = '0;
			r.kind = m_tuser;
			r.quantity = m_tdata[3:0];
			r.value_bits = m_tdata[35:4];
			r.frame_type = m_tdata[37:36];
			r.control_value = m_tdata[45:38];
			r.length_value = m_tdata[53:46];
			r.message_id = m_tdata[61:54];
			r.nack_code = m_tdata[69:62];
			r.length_error = m_tdata[70];
			r.last_of_run = m_tlast;
			sb.check_beat(r);
		end
	end

	// Receiver backpressure: rotating patterns, plus one long hold-off on request.
	initial begin
		int mode;
		int left;
		m_tready = 1'b0;
		mode = 0;
		left = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (stall_request) begin
				stall_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 96);
				end
				left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= left[2];
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task send_beat(input logic [7:0] rx, input logic sof);
		if (burst_left == 0) begin
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(rx, sof);
	endtask

	task send_span(input int from, input int upto);
		for (int i = from; i < upto; i++)
			send_beat(frame_q[i], i == 0);
	endtask

	task wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_mask(input logic [5:0] m);
		cfg_wr_data <= m;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_mask(m);
		mask_writes++;
	endtask

	function int data_payload_len(logic [5:0] m);
		return 2 + 6 * m[0] + 6 * m[1] + 6 * m[2] + 4 * m[3] + 2 * m[4] + 12 * m[5];
	endfunction

	function void push_frame(logic [7:0] ctrl, int len, logic [7:0] id, int pay);
		frame_q.delete();
		frame_q.push_back(ctrl);
		frame_q.push_back(8'(len));
		if (len > imuf_pkg::MAX_LENGTH) return;
		frame_q.push_back(id);
		for (int i = 0; i < pay; i++) frame_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	function void build_random_frame();
		int pick;
		int len;
		logic [7:0] ctrl;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			len = data_payload_len(sb.mask) + 1;
			if ($urandom_range(0, 1)) len = len + $urandom_range(0, 10) - 6;
			if (len < 4) len = 4;
			if (len > imuf_pkg::MAX_LENGTH) len = imuf_pkg::MAX_LENGTH;
			push_frame(imuf_pkg::DATA_CONTROL, len, imuf_pkg::DATA_ID, len - 1);
		end else if (pick < 75) begin
			case ($urandom_range(0, 4))
				0: ctrl = CTRL_CONTROL;
				1: ctrl = CTRL_ACK;
				2: ctrl = CTRL_NACK;
				3: ctrl = imuf_pkg::DATA_CONTROL;
				default: ctrl = 8'($urandom_range(0, 255));
			endcase
			len = $urandom_range(0, 12);
			push_frame(ctrl, len, 8'($urandom_range(0, 255)), (len > 1) ? len - 1 : 0);
		end else if (pick < 85) begin
			len = $urandom_range(0, 3) == 0 ? 127 + 128 * $urandom_range(0, 1)
				: $urandom_range(127, 255);
			push_frame(8'($urandom_range(0, 255)), len, 8'h00, 0);
		end else if (pick < 95) begin
			len = $urandom_range(0, 3);
			push_frame(imuf_pkg::DATA_CONTROL, len, imuf_pkg::DATA_ID, (len > 1) ? len - 1 : 0);
		end else begin
			len = imuf_pkg::MAX_LENGTH;
			ctrl = $urandom_range(0, 1) ? imuf_pkg::DATA_CONTROL : 8'($urandom_range(0, 255));
			push_frame(ctrl, len, imuf_pkg::DATA_ID, len - 1);
		end
	endfunction

	initial begin
		int start_count;
		int phase_start;
		int phase_no;
		int cut;
		logic [5:0] m;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		burst_left = 0;
		gaps_on = 1'b0;
		stall_request = 1'b0;
		mask_writes = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Directed: pressure only, then the header corner cases.
		write_mask(6'b001000);
		send_beat(8'hFF, 1'b0);
		frame_q = '{CTRL_NACK, 8'd127};
		send_span(0, 2);
		frame_q = '{8'h55, 8'd0, 8'hAA};
		send_span(0, 3);
		frame_q = '{CTRL_ACK, 8'd1, 8'h01};
		send_span(0, 3);
		frame_q = '{CTRL_NACK, 8'd3, imuf_pkg::DATA_ID, 8'h07, 8'h00};
		send_span(0, 5);
		frame_q = '{imuf_pkg::DATA_CONTROL, 8'd10, imuf_pkg::DATA_ID, 8'h12};
		send_span(0, 4);
		frame_q = '{imuf_pkg::DATA_CONTROL, 8'd7, imuf_pkg::DATA_ID, 8'hFF, 8'hFF, 8'h80,
			8'h00, 8'h00, 8'h01};
		send_span(0, 9);
		wait_idle();

		start_count = sb.counted;
		phase_no = 0;
		while (sb.counted - start_count < RANDOM_ITEMS) begin
			wait_idle();
			case (phase_no % 4)
				0: m = 6'd63;
				1: m = 6'd0;
				default: m = 6'($urandom_range(0, 63));
			endcase
			write_mask(m);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (phase_no == 2) stall_request = 1'b1;
			if (phase_no % 3 == 1) begin
				// mask rewritten while a data frame is partly received
				push_frame(imuf_pkg::DATA_CONTROL, data_payload_len(6'd63) + 1, imuf_pkg::DATA_ID,
					data_payload_len(6'd63));
				cut = $urandom_range(4, frame_q.size() - 2);
				send_span(0, cut);
				wait_idle();
				write_mask(6'($urandom_range(0, 63)));
				send_span(cut, frame_q.size());
			end
			phase_start = sb.counted;
			while (sb.counted - phase_start < PHASE_ITEMS &&
					sb.counted - start_count < RANDOM_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
				build_random_frame();
				if ($urandom_range(0, 9) == 0) send_span(0, $urandom_range(1, frame_q.size() - 1));
				else send_span(0, frame_q.size());
			end
			phase_no++;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d frames (%0d parsed beats) across %0d sensor mask writes.",
			sb.frames_started, sb.counted, mask_writes);
		$display("Checked %0d decoded values and %0d frame summaries.",
			sb.values_seen, sb.summaries_seen);
		if (sb.expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				sb.expected_results.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
